>>> rtl/fcca_pkg.sv
// Shared types and constants of the FAT cluster chain allocator.
// No dependencies; every other file of the block except fcca_ram refers to it by scoped names.
package fcca_pkg;

    localparam int unsigned CLUSTERS_DEF      = 16;
    localparam int unsigned DIR_ENTRIES_DEF   = 16;
    localparam int unsigned CLUSTER_BYTES_DEF = 1024;

    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_REINIT = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_DIR_FULL  = 3'd2,
        ST_NO_SPACE  = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] name_key;
        logic [23:0] size_bytes;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] first_cluster;
        logic       first_cluster_valid;
        logic [4:0] cluster_count;
        logic [3:0] directory_slot;
        logic [4:0] free_clusters;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FIND,
        S_ALLOC,
        S_DRD,
        S_DCMP,
        S_WRD,
        S_WNX,
        S_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    latch;
        logic    slot_clr;
        logic    slot_inc;
        logic    alloc_init;
        logic    alloc_step;
        logic    alloc_fin;
        logic    walk_init;
        logic    walk_take;
        logic    walk_next;
        logic    del_fin;
        logic    reinit;
        logic    res_we;
        logic    res_zero;
        t_status res_code;
        logic    load_out;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       too_large;
        logic       no_space;
        logic       cur_active;
        logic       slot_last;
        logic       name_hit;
        logic       clu_used;
        logic       alloc_done;
        logic       has_start;
        logic       rd_end;
        logic       out_free;
    } t_sts;

endpackage

>>> rtl/fcca_req_if.sv
// Command channel: valid/ready handshake carrying one request item.
// Depends on fcca_pkg for the payload type.
interface fcca_req_if;
    logic              valid;
    logic              ready;
    fcca_pkg::t_req    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/fcca_rsp_if.sv
// Result channel: valid/ready handshake carrying one result item.
// Depends on fcca_pkg for the payload type.
interface fcca_rsp_if;
    logic              valid;
    logic              ready;
    fcca_pkg::t_rsp    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/fcca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/fcca_ctrl.sv
// Sequencing state machine of the allocator: scans, allocation and chain walk.
// Depends on fcca_pkg; drives fcca_dp through t_ctl and reads t_sts.
module fcca_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  fcca_pkg::t_sts i_sts,
    output fcca_pkg::t_ctl o_ctl
);

    fcca_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcca_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fcca_pkg::S_IDLE: begin
                if (i_in_valid) n_state = fcca_pkg::S_DECODE;
            end
            fcca_pkg::S_DECODE: begin
                unique case (i_sts.cmd)
                    fcca_pkg::CMD_CREATE:
                        n_state = i_sts.too_large ? fcca_pkg::S_RESP : fcca_pkg::S_FIND;
                    fcca_pkg::CMD_DELETE: n_state = fcca_pkg::S_DRD;
                    default:              n_state = fcca_pkg::S_RESP;
                endcase
            end
            fcca_pkg::S_FIND: begin
                if (!i_sts.cur_active) begin
                    n_state = i_sts.no_space ? fcca_pkg::S_RESP : fcca_pkg::S_ALLOC;
                end else if (i_sts.slot_last) begin
                    n_state = fcca_pkg::S_RESP;
                end
            end
            fcca_pkg::S_ALLOC: begin
                if (i_sts.alloc_done) n_state = fcca_pkg::S_RESP;
            end
            fcca_pkg::S_DRD: n_state = fcca_pkg::S_DCMP;
            fcca_pkg::S_DCMP: begin
                if (i_sts.cur_active && i_sts.name_hit) begin
                    n_state = fcca_pkg::S_WRD;
                end else if (i_sts.slot_last) begin
                    n_state = fcca_pkg::S_RESP;
                end else begin
                    n_state = fcca_pkg::S_DRD;
                end
            end
            fcca_pkg::S_WRD: begin
                n_state = (!i_sts.has_start || !i_sts.clu_used) ?
                          fcca_pkg::S_RESP : fcca_pkg::S_WNX;
            end
            fcca_pkg::S_WNX: begin
                n_state = i_sts.rd_end ? fcca_pkg::S_RESP : fcca_pkg::S_WRD;
            end
            fcca_pkg::S_RESP: begin
                if (i_sts.out_free) n_state = fcca_pkg::S_IDLE;
            end
            default: n_state = fcca_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctl          = '0;
        o_ctl.res_code = fcca_pkg::ST_OK;
        o_in_ready     = 1'b0;
        unique case (r_state)
            fcca_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctl.latch = i_in_valid;
            end
            fcca_pkg::S_DECODE: begin
                unique case (i_sts.cmd)
                    fcca_pkg::CMD_CREATE: begin
                        if (i_sts.too_large) begin
                            o_ctl.res_we   = 1'b1;
                            o_ctl.res_zero = 1'b1;
                            o_ctl.res_code = fcca_pkg::ST_TOO_LARGE;
                        end else begin
                            o_ctl.slot_clr = 1'b1;
                        end
                    end
                    fcca_pkg::CMD_DELETE: o_ctl.slot_clr = 1'b1;
                    fcca_pkg::CMD_REINIT: begin
                        o_ctl.reinit   = 1'b1;
                        o_ctl.res_we   = 1'b1;
                        o_ctl.res_zero = 1'b1;
                    end
                    default: begin
                        o_ctl.res_we   = 1'b1;
                        o_ctl.res_zero = 1'b1;
                    end
                endcase
            end
            fcca_pkg::S_FIND: begin
                if (!i_sts.cur_active) begin
                    if (i_sts.no_space) begin
                        o_ctl.res_we   = 1'b1;
                        o_ctl.res_zero = 1'b1;
                        o_ctl.res_code = fcca_pkg::ST_NO_SPACE;
                    end else begin
                        o_ctl.alloc_init = 1'b1;
                    end
                end else if (i_sts.slot_last) begin
                    o_ctl.res_we   = 1'b1;
                    o_ctl.res_zero = 1'b1;
                    o_ctl.res_code = fcca_pkg::ST_DIR_FULL;
                end else begin
                    o_ctl.slot_inc = 1'b1;
                end
            end
            fcca_pkg::S_ALLOC: begin
                if (i_sts.alloc_done) begin
                    o_ctl.alloc_fin = 1'b1;
                    o_ctl.res_we    = 1'b1;
                end else begin
                    o_ctl.alloc_step = 1'b1;
                end
            end
            fcca_pkg::S_DRD: ;
            fcca_pkg::S_DCMP: begin
                if (i_sts.cur_active && i_sts.name_hit) begin
                    o_ctl.walk_init = 1'b1;
                end else if (i_sts.slot_last) begin
                    o_ctl.res_we   = 1'b1;
                    o_ctl.res_zero = 1'b1;
                    o_ctl.res_code = fcca_pkg::ST_NOT_FOUND;
                end else begin
                    o_ctl.slot_inc = 1'b1;
                end
            end
            fcca_pkg::S_WRD: begin
                if (!i_sts.has_start || !i_sts.clu_used) begin
                    o_ctl.del_fin = 1'b1;
                    o_ctl.res_we  = 1'b1;
                end else begin
                    o_ctl.walk_take = 1'b1;
                end
            end
            fcca_pkg::S_WNX: begin
                if (i_sts.rd_end) begin
                    o_ctl.del_fin = 1'b1;
                    o_ctl.res_we  = 1'b1;
                end else begin
                    o_ctl.walk_next = 1'b1;
                end
            end
            fcca_pkg::S_RESP: o_ctl.load_out = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

>>> rtl/fcca_dp.sv
// Datapath of the allocator: used/active bitmaps, link and directory RAMs,
// counters and the result register. Depends on fcca_pkg and fcca_ram.
module fcca_dp #(
    parameter int unsigned CLUSTERS      = fcca_pkg::CLUSTERS_DEF,
    parameter int unsigned DIR_ENTRIES   = fcca_pkg::DIR_ENTRIES_DEF,
    parameter int unsigned CLUSTER_BYTES = fcca_pkg::CLUSTER_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fcca_pkg::t_ctl i_ctl,
    output fcca_pkg::t_sts o_sts,
    input  fcca_pkg::t_req i_req,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output fcca_pkg::t_rsp o_out_data
);

    localparam int CW  = $clog2(CLUSTERS);
    localparam int FCW = $clog2(CLUSTERS + 1);
    localparam int DW  = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam logic [31:0] MAX_BYTES = 32'(CLUSTERS * CLUSTER_BYTES);
    localparam logic [31:0] CB32      = 32'(CLUSTER_BYTES);

    logic [1:0]             r_cmd;
    logic [63:0]            r_name;
    logic [23:0]            r_size;
    logic [CLUSTERS-1:0]    r_used;
    logic [DIR_ENTRIES-1:0] r_active;
    logic [FCW-1:0]         r_free;
    logic [DW-1:0]          r_slot;
    logic [CW-1:0]          r_clu;
    logic [CW-1:0]          r_prev;
    logic [CW-1:0]          r_start;
    logic                   r_has;
    logic [FCW-1:0]         r_taken;
    logic [31:0]            r_acc;
    fcca_pkg::t_status      r_status;
    logic                   r_rzero;
    logic                   r_out_valid;
    fcca_pkg::t_rsp         r_out_data;

    logic          take;
    logic          link_we;
    logic [CW:0]   link_wdata;
    logic [CW:0]   link_rdata;
    logic [63:0]   name_rdata;
    logic [CW:0]   start_rdata;

    assign take = i_ctl.alloc_step && !r_used[r_clu];
    assign link_we = (take && r_has) || (i_ctl.alloc_fin && r_has);
    assign link_wdata = i_ctl.alloc_fin ? {1'b1, {CW{1'b0}}} : {1'b0, r_clu};

    fcca_ram #(.WIDTH(CW + 1), .DEPTH(CLUSTERS)) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (link_we),
        .i_waddr(r_prev),
        .i_wdata(link_wdata),
        .i_raddr(r_clu),
        .o_rdata(link_rdata)
    );

    fcca_ram #(.WIDTH(64), .DEPTH(DIR_ENTRIES)) u_name_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctl.alloc_fin),
        .i_waddr(r_slot),
        .i_wdata(r_name),
        .i_raddr(r_slot),
        .o_rdata(name_rdata)
    );

    fcca_ram #(.WIDTH(CW + 1), .DEPTH(DIR_ENTRIES)) u_start_ram (
        .i_clk  (i_clk),
        .i_we   (i_ctl.alloc_fin),
        .i_waddr(r_slot),
        .i_wdata({r_has, r_start}),
        .i_raddr(r_slot),
        .o_rdata(start_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_active    <= '0;
            r_free      <= FCW'(CLUSTERS);
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.reinit) begin
                r_used   <= '0;
                r_active <= '0;
                r_free   <= FCW'(CLUSTERS);
            end
            if (take) begin
                r_used[r_clu] <= 1'b1;
                r_free        <= r_free - 1'b1;
            end
            if (i_ctl.walk_take) begin
                r_used[r_clu] <= 1'b0;
                r_free        <= r_free + 1'b1;
            end
            if (i_ctl.alloc_fin) r_active[r_slot] <= 1'b1;
            if (i_ctl.del_fin)   r_active[r_slot] <= 1'b0;
            if (i_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd  <= i_req.command;
            r_name <= i_req.name_key;
            r_size <= i_req.size_bytes;
        end
        if (i_ctl.slot_clr) r_slot <= '0;
        if (i_ctl.slot_inc) r_slot <= r_slot + 1'b1;
        if (i_ctl.alloc_init) begin
            r_clu   <= '0;
            r_acc   <= '0;
            r_taken <= '0;
            r_has   <= 1'b0;
        end
        if (i_ctl.alloc_step) begin
            r_clu <= r_clu + 1'b1;
        end
        if (take) begin
            if (!r_has) r_start <= r_clu;
            r_has   <= 1'b1;
            r_prev  <= r_clu;
            r_taken <= r_taken + 1'b1;
            r_acc   <= r_acc + CB32;
        end
        if (i_ctl.walk_init) begin
            r_has   <= start_rdata[CW];
            r_start <= start_rdata[CW-1:0];
            r_clu   <= start_rdata[CW-1:0];
            r_taken <= '0;
        end
        if (i_ctl.walk_take) r_taken <= r_taken + 1'b1;
        if (i_ctl.walk_next) r_clu   <= link_rdata[CW-1:0];
        if (i_ctl.res_we) begin
            r_status <= i_ctl.res_code;
            r_rzero  <= i_ctl.res_zero;
        end
        if (i_ctl.load_out) begin
            r_out_data.status              <= r_status;
            r_out_data.first_cluster       <= (r_rzero || !r_has) ? 4'd0 : 4'(r_start);
            r_out_data.first_cluster_valid <= !r_rzero && r_has;
            r_out_data.cluster_count       <= r_rzero ? 5'd0 : 5'(r_taken);
            r_out_data.directory_slot      <= r_rzero ? 4'd0 : 4'(r_slot);
            r_out_data.free_clusters       <= 5'(r_free);
        end
    end

    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.too_large  = {8'd0, r_size} > MAX_BYTES;
        o_sts.no_space   = (32'(r_free) * CB32) < {8'd0, r_size};
        o_sts.cur_active = r_active[r_slot];
        o_sts.slot_last  = (r_slot == DW'(DIR_ENTRIES - 1));
        o_sts.name_hit   = (name_rdata == r_name);
        o_sts.clu_used   = r_used[r_clu];
        o_sts.alloc_done = (r_acc >= {8'd0, r_size});
        o_sts.has_start  = r_has;
        o_sts.rd_end     = link_rdata[CW];
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> rtl/fat_cluster_chain_allocator_unit.sv
// FAT-style cluster chain allocator with a flat root directory: top level.
// Depends on fcca_pkg, fcca_req_if, fcca_rsp_if, fcca_ctrl, fcca_dp, fcca_ram.
//
// The unit takes one command at a time (create, delete, reinitialize) and
// returns exactly one result per command. A create first scans the directory
// one slot per cycle for the lowest free slot, then sweeps the cluster table
// one cluster per cycle, linking free clusters until the size is covered. A
// delete reads the directory name RAM slot by slot, with a read state and a
// compare state per slot, until the name matches, then walks the chain
// through the link RAM with a free state and a next state per freed cluster,
// since each hop needs the registered read of the previous entry. The result
// sits in an output register, so the next command is accepted while a result
// waits for its transfer. Cluster occupancy and directory activity live in
// flip-flop bitmaps cleared by reset, so there is no clearing pass after
// reset.
module fat_cluster_chain_allocator_unit #(
    parameter int unsigned CLUSTERS      = fcca_pkg::CLUSTERS_DEF,
    parameter int unsigned DIR_ENTRIES   = fcca_pkg::DIR_ENTRIES_DEF,
    parameter int unsigned CLUSTER_BYTES = fcca_pkg::CLUSTER_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fcca_req_if.sink   i_req,
    fcca_rsp_if.source o_rsp
);

    fcca_pkg::t_ctl ctl;
    fcca_pkg::t_sts sts;

    // sequencer: one command in flight, handshakes the command channel
    fcca_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_req.valid),
        .o_in_ready(i_req.ready),
        .i_sts     (sts),
        .o_ctl     (ctl)
    );

    // storage, counters and the result register
    fcca_dp #(
        .CLUSTERS     (CLUSTERS),
        .DIR_ENTRIES  (DIR_ENTRIES),
        .CLUSTER_BYTES(CLUSTER_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .i_req      (i_req.data),
        .o_out_valid(o_rsp.valid),
        .i_out_ready(o_rsp.ready),
        .o_out_data (o_rsp.data)
    );

endmodule

>>> rtl/fcca_checker.sv
// Port-level checks of the allocator, bound to the top level.
// Depends on fcca_pkg and fat_cluster_chain_allocator_unit.
module fcca_checker #(
    parameter int unsigned CLUSTERS = fcca_pkg::CLUSTERS_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input fcca_pkg::t_rsp i_out_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result dropped or changed");

    // one command at a time: no new transfer right after one
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command accepted while busy");

    // failed commands report no cluster, count or slot
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status != fcca_pkg::ST_OK) |->
        !i_out_data.first_cluster_valid && (i_out_data.cluster_count == 5'd0) &&
        (i_out_data.directory_slot == 4'd0))
        else $error("failed command reports allocation");

    // a start cluster implies a nonzero count
    a_first_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.first_cluster_valid |->
        (i_out_data.cluster_count != 5'd0))
        else $error("start cluster without clusters");

    // free count never exceeds the table
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (32'(i_out_data.free_clusters) <= 32'(CLUSTERS)))
        else $error("free count out of range");

endmodule

bind fat_cluster_chain_allocator_unit fcca_checker #(.CLUSTERS(CLUSTERS)) u_fcca_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_req.valid),
    .i_in_ready (i_req.ready),
    .i_out_valid(o_rsp.valid),
    .i_out_ready(o_rsp.ready),
    .i_out_data (o_rsp.data)
);
